@@ hw/rtl/mcrre_pkg.sv @@
package mcrre_pkg;

  // Sizing
  localparam int unsigned FIFO_DEPTH_DEF = 1024;
  localparam int unsigned ENTRY_W        = 14;
  localparam int unsigned OUTST_W        = 11;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 16;
  localparam int unsigned RESEND_W       = 5;
  localparam int unsigned TICK_W         = 16;

  localparam logic [RESEND_W-1:0] RESEND_MAX = '1;
  localparam logic [TICK_W-1:0]   TICK_MAX   = '1;

  // Input function codes
  localparam logic [1:0] FUNC_ENQ  = 2'd0;
  localparam logic [1:0] FUNC_TICK = 2'd1;
  localparam logic [1:0] FUNC_RX   = 2'd2;

  // Received type nibble of a control change
  localparam logic [3:0] MSG_CC = 4'd11;

  // Result kinds
  localparam logic [1:0] KIND_SEND    = 2'd0;
  localparam logic [1:0] KIND_REPLY   = 2'd1;
  localparam logic [1:0] KIND_TIMEOUT = 2'd2;
  localparam logic [1:0] KIND_REJECT  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_PORT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL_CHANNEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CMD_CC       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VAL_CC       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_IVAL   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT  = 3'd5;

  // Configuration reset values
  localparam logic [4:0]  RST_ACTIVE_PORT  = 5'h1F;
  localparam logic [4:0]  RST_CTRL_CHANNEL = 5'd8;
  localparam logic [6:0]  RST_CMD_CC       = 7'd31;
  localparam logic [6:0]  RST_VAL_CC       = 7'd63;
  localparam logic [15:0] RST_RETRY_IVAL   = 16'd100;
  localparam logic [3:0]  RST_RETRY_LIMIT  = 4'd10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EMIT_A,
    ST_EMIT_B
  } state_e;

  typedef struct packed {
    logic [1:0] func;
    logic [6:0] command;
    logic [6:0] command_value;
    logic [3:0] msg_type;
    logic [6:0] param_one;
    logic [6:0] param_two;
  } in_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         port;
    logic [4:0]         channel;
    logic [6:0]         cc_number;
    logic [6:0]         cc_value;
    logic               reply_matched;
    logic [6:0]         request_value;
    logic [OUTST_W-1:0] outstanding;
    logic               last;
  } out_t;

  typedef struct packed {
    logic signed [4:0] active_port;
    logic [4:0]        control_channel;
    logic [6:0]        command_cc_number;
    logic [6:0]        value_cc_number;
    logic [15:0]       retry_interval;
    logic [3:0]        retry_limit;
  } cfg_t;

  // Assemble one result word
  function automatic out_t mk_res(
    input logic [1:0]         kind,
    input logic [3:0]         port,
    input logic [4:0]         channel,
    input logic [6:0]         num,
    input logic [6:0]         val,
    input logic               matched,
    input logic [6:0]         req,
    input logic [OUTST_W-1:0] outst,
    input logic               last
  );
    out_t r;
    r.kind          = kind;
    r.port          = port;
    r.channel       = channel;
    r.cc_number     = num;
    r.cc_value      = val;
    r.reply_matched = matched;
    r.request_value = req;
    r.outstanding   = outst;
    r.last          = last;
    return r;
  endfunction

endpackage

@@ hw/rtl/mcrre_mem.sv @@
module mcrre_mem #(
  parameter int unsigned DEPTH = mcrre_pkg::FIFO_DEPTH_DEF,
  localparam int unsigned IDX_W = $clog2(DEPTH)
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [IDX_W-1:0]             waddr_i,
  input  logic [mcrre_pkg::ENTRY_W-1:0] wdata_i,
  input  logic                         re_i,
  input  logic [IDX_W-1:0]             raddr_i,
  output logic [mcrre_pkg::ENTRY_W-1:0] rdata_o
);

  logic [mcrre_pkg::ENTRY_W-1:0] mem_q [DEPTH];
  logic [mcrre_pkg::ENTRY_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/mcrre_core.sv @@
module mcrre_core #(
  parameter int unsigned DEPTH = mcrre_pkg::FIFO_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mcrre_pkg::cfg_t   cfg_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mcrre_pkg::in_t    in_data_i,
  input  logic              slot_free_i,
  output logic              res_load_o,
  output mcrre_pkg::out_t   res_data_o
);

  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 2);

  mcrre_pkg::state_e state_q, state_d;

  logic [IDX_W-1:0]               wr_idx_q, wr_idx_d;
  logic [IDX_W-1:0]               rd_idx_q, rd_idx_d;
  logic [FILL_W-1:0]              fill_q, fill_d;
  logic [CNT_W-1:0]               outst_q, outst_d;
  logic [6:0]                     pend_cmd_q, pend_cmd_d;
  logic [6:0]                     pend_val_q, pend_val_d;
  logic [mcrre_pkg::RESEND_W-1:0] resend_q, resend_d;
  logic [mcrre_pkg::TICK_W-1:0]   ticks_q, ticks_d;
  logic [6:0]                     held_q, held_d;
  mcrre_pkg::out_t                res0_q, res0_d, res1_q, res1_d;
  logic                           two_q, two_d;

  logic                           accept;
  logic                           go_fetch;
  logic                           has_res;
  logic                           send_ok;
  logic [mcrre_pkg::TICK_W-1:0]   ticks_inc;
  logic [mcrre_pkg::OUTST_W-1:0]  outst_now;
  logic [mcrre_pkg::OUTST_W-1:0]  outst_new;
  logic                           matched;
  logic                           mem_we;
  logic                           mem_re;
  logic [mcrre_pkg::ENTRY_W-1:0]  mem_rdata;

  assign accept  = in_valid_i && (state_q == mcrre_pkg::ST_IDLE);
  // Port active and channel in 1..16
  assign send_ok = !cfg_i.active_port[4] && (cfg_i.control_channel != 5'd0) &&
                   !(cfg_i.control_channel[4] && (cfg_i.control_channel[3:0] != 4'd0));
  assign ticks_inc = (ticks_q != mcrre_pkg::TICK_MAX) ? ticks_q + 1'b1 : ticks_q;
  assign outst_now = mcrre_pkg::OUTST_W'(outst_q);
  assign outst_new = mcrre_pkg::OUTST_W'(outst_q - ((outst_q != '0) ? 1'b1 : 1'b0));
  assign matched   = (held_q != 7'd0) && (held_q == pend_cmd_q);

  // Command queue storage; a tick only reads, an enqueue only writes
  mcrre_mem #(
    .DEPTH(DEPTH)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(wr_idx_q),
    .wdata_i({in_data_i.command, in_data_i.command_value}),
    .re_i   (mem_re),
    .raddr_i(rd_idx_q),
    .rdata_o(mem_rdata)
  );

  // Decide each item: read state, modify, write back
  always_comb begin
    wr_idx_d   = wr_idx_q;
    rd_idx_d   = rd_idx_q;
    fill_d     = fill_q;
    outst_d    = outst_q;
    pend_cmd_d = pend_cmd_q;
    pend_val_d = pend_val_q;
    resend_d   = resend_q;
    ticks_d    = ticks_q;
    held_d     = held_q;
    res0_d     = res0_q;
    res1_d     = res1_q;
    two_d      = two_q;
    go_fetch   = 1'b0;
    has_res    = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;

    if (accept) begin
      unique case (in_data_i.func)
        mcrre_pkg::FUNC_ENQ: begin
          if (cfg_i.active_port[4] || (in_data_i.command == 7'd0) ||
              (fill_q == FILL_W'(DEPTH))) begin
            res0_d  = mcrre_pkg::mk_res(mcrre_pkg::KIND_REJECT, 4'd0, 5'd0,
                        in_data_i.command, in_data_i.command_value, 1'b0, 7'd0,
                        outst_now, 1'b1);
            two_d   = 1'b0;
            has_res = 1'b1;
          end else begin
            mem_we   = 1'b1;
            wr_idx_d = (wr_idx_q == IDX_W'(DEPTH - 1)) ? '0 : wr_idx_q + 1'b1;
            fill_d   = fill_q + 1'b1;
            outst_d  = outst_q + 1'b1;
          end
        end
        mcrre_pkg::FUNC_TICK: begin
          if (pend_cmd_q == 7'd0) begin
            if (fill_q != '0) begin
              mem_re   = 1'b1;
              go_fetch = 1'b1;
            end
          end else if (resend_q > {1'b0, cfg_i.retry_limit}) begin
            // Give up on the pending command
            res0_d     = mcrre_pkg::mk_res(mcrre_pkg::KIND_TIMEOUT, 4'd0, 5'd0, 7'd0,
                           pend_cmd_q, 1'b0, pend_val_q, outst_new, 1'b1);
            two_d      = 1'b0;
            has_res    = 1'b1;
            resend_d   = '0;
            pend_cmd_d = 7'd0;
            outst_d    = outst_q - ((outst_q != '0) ? 1'b1 : 1'b0);
          end else if (ticks_inc > cfg_i.retry_interval) begin
            // Resend the pending pair, emitted only if sending is enabled
            resend_d = (resend_q != mcrre_pkg::RESEND_MAX) ? resend_q + 1'b1 : resend_q;
            ticks_d  = '0;
            res0_d   = mcrre_pkg::mk_res(mcrre_pkg::KIND_SEND, cfg_i.active_port[3:0],
                         cfg_i.control_channel, cfg_i.command_cc_number, pend_cmd_q,
                         1'b0, 7'd0, outst_now, 1'b0);
            res1_d   = mcrre_pkg::mk_res(mcrre_pkg::KIND_SEND, cfg_i.active_port[3:0],
                         cfg_i.control_channel, cfg_i.value_cc_number, pend_val_q,
                         1'b0, 7'd0, outst_now, 1'b1);
            two_d    = 1'b1;
            has_res  = send_ok;
          end else begin
            ticks_d = ticks_inc;
          end
        end
        mcrre_pkg::FUNC_RX: begin
          if (in_data_i.msg_type == mcrre_pkg::MSG_CC) begin
            if (in_data_i.param_one == cfg_i.command_cc_number) begin
              held_d = in_data_i.param_two;
            end else if (in_data_i.param_one == cfg_i.value_cc_number) begin
              held_d  = 7'd0;
              res0_d  = mcrre_pkg::mk_res(mcrre_pkg::KIND_REPLY, 4'd0, 5'd0, held_q,
                          in_data_i.param_two, matched, pend_val_q,
                          matched ? outst_new : outst_now, 1'b1);
              two_d   = 1'b0;
              has_res = 1'b1;
              if (matched) begin
                pend_cmd_d = 7'd0;
                outst_d    = outst_q - ((outst_q != '0) ? 1'b1 : 1'b0);
              end
            end
          end
        end
        default: begin
        end
      endcase
    end else if (state_q == mcrre_pkg::ST_FETCH) begin
      // Queue head arrived from memory: make it pending and, if sending is enabled, send it
      pend_cmd_d = mem_rdata[13:7];
      pend_val_d = mem_rdata[6:0];
      resend_d   = '0;
      ticks_d    = '0;
      rd_idx_d   = (rd_idx_q == IDX_W'(DEPTH - 1)) ? '0 : rd_idx_q + 1'b1;
      fill_d     = fill_q - 1'b1;
      res0_d     = mcrre_pkg::mk_res(mcrre_pkg::KIND_SEND, cfg_i.active_port[3:0],
                     cfg_i.control_channel, cfg_i.command_cc_number, mem_rdata[13:7],
                     1'b0, 7'd0, outst_now, 1'b0);
      res1_d     = mcrre_pkg::mk_res(mcrre_pkg::KIND_SEND, cfg_i.active_port[3:0],
                     cfg_i.control_channel, cfg_i.value_cc_number, mem_rdata[6:0],
                     1'b0, 7'd0, outst_now, 1'b1);
      two_d      = 1'b1;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mcrre_pkg::ST_IDLE: begin
        if (go_fetch) begin
          state_d = mcrre_pkg::ST_FETCH;
        end else if (has_res) begin
          state_d = mcrre_pkg::ST_EMIT_A;
        end
      end
      mcrre_pkg::ST_FETCH: begin
        state_d = send_ok ? mcrre_pkg::ST_EMIT_A : mcrre_pkg::ST_IDLE;
      end
      mcrre_pkg::ST_EMIT_A: begin
        if (slot_free_i) begin
          state_d = two_q ? mcrre_pkg::ST_EMIT_B : mcrre_pkg::ST_IDLE;
        end
      end
      mcrre_pkg::ST_EMIT_B: begin
        if (slot_free_i) begin
          state_d = mcrre_pkg::ST_IDLE;
        end
      end
      default: state_d = mcrre_pkg::ST_IDLE;
    endcase
  end

  // Handshake and result handoff
  always_comb begin
    in_stall_o = (state_q != mcrre_pkg::ST_IDLE);
    res_load_o = 1'b0;
    res_data_o = res0_q;
    unique case (state_q)
      mcrre_pkg::ST_EMIT_A: res_load_o = slot_free_i;
      mcrre_pkg::ST_EMIT_B: begin
        res_load_o = slot_free_i;
        res_data_o = res1_q;
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= mcrre_pkg::ST_IDLE;
      wr_idx_q   <= '0;
      rd_idx_q   <= '0;
      fill_q     <= '0;
      outst_q    <= '0;
      pend_cmd_q <= '0;
      pend_val_q <= '0;
      resend_q   <= '0;
      ticks_q    <= '0;
      held_q     <= '0;
      two_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      wr_idx_q   <= wr_idx_d;
      rd_idx_q   <= rd_idx_d;
      fill_q     <= fill_d;
      outst_q    <= outst_d;
      pend_cmd_q <= pend_cmd_d;
      pend_val_q <= pend_val_d;
      resend_q   <= resend_d;
      ticks_q    <= ticks_d;
      held_q     <= held_d;
      two_q      <= two_d;
    end
  end

  // Result words
  always_ff @(posedge clk_i) begin
    res0_q <= res0_d;
    res1_q <= res1_d;
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(DEPTH))
    else $error("queue fill above depth");

  a_outst_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outst_q == CNT_W'(fill_q) + CNT_W'(pend_cmd_q != 7'd0))
    else $error("outstanding count out of step with queue and pending command");

  a_fetch_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mcrre_pkg::ST_FETCH) |->
      $past(accept && (in_data_i.func == mcrre_pkg::FUNC_TICK)))
    else $error("fetch without an accepted tick");

  a_fetch_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mcrre_pkg::ST_FETCH) |-> (fill_q != '0) && (pend_cmd_q == 7'd0))
    else $error("fetch from empty queue or with a command pending");

endmodule

@@ hw/rtl/midi_command_reply_retry_engine.sv @@
// Timing: an accepted word's result is registered in the core's result words and then loaded
// into the output register; a tick that dequeues first waits on the queue memory read.
// The input stalls while the core is not idle, so a new word is taken only once the results
// of the last one are handed off to the output register; output stall holds the engine.
// Reset: asynchronous, active low; queue empty, nothing pending, registers at defaults.
// The queue memory needs no clearing pass: entries are read only after being written.
module midi_command_reply_retry_engine #(
  parameter int unsigned FIFO_DEPTH = mcrre_pkg::FIFO_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  mcrre_pkg::in_t                  in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output mcrre_pkg::out_t                 out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mcrre_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mcrre_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  mcrre_pkg::cfg_t cfg_q;
  mcrre_pkg::out_t out_q;
  logic            out_valid_q, out_valid_d;
  logic            slot_free;
  logic            res_load;
  mcrre_pkg::out_t res_data;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_port       <= mcrre_pkg::RST_ACTIVE_PORT;
      cfg_q.control_channel   <= mcrre_pkg::RST_CTRL_CHANNEL;
      cfg_q.command_cc_number <= mcrre_pkg::RST_CMD_CC;
      cfg_q.value_cc_number   <= mcrre_pkg::RST_VAL_CC;
      cfg_q.retry_interval    <= mcrre_pkg::RST_RETRY_IVAL;
      cfg_q.retry_limit       <= mcrre_pkg::RST_RETRY_LIMIT;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mcrre_pkg::REG_ACTIVE_PORT:  cfg_q.active_port       <= cfg_data_i[4:0];
        mcrre_pkg::REG_CTRL_CHANNEL: cfg_q.control_channel   <= cfg_data_i[4:0];
        mcrre_pkg::REG_CMD_CC:       cfg_q.command_cc_number <= cfg_data_i[6:0];
        mcrre_pkg::REG_VAL_CC:       cfg_q.value_cc_number   <= cfg_data_i[6:0];
        mcrre_pkg::REG_RETRY_IVAL:   cfg_q.retry_interval    <= cfg_data_i[15:0];
        mcrre_pkg::REG_RETRY_LIMIT:  cfg_q.retry_limit       <= cfg_data_i[3:0];
        default: begin
        end
      endcase
    end
  end

  mcrre_core #(
    .DEPTH(FIFO_DEPTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .slot_free_i(slot_free),
    .res_load_o (res_load),
    .res_data_o (res_data)
  );

  // Output register: free when empty or being taken
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign out_valid_d = res_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_q <= res_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
